// File: design/grid_maze_shortest_path_top_macros.svh
// Assertion macros for the grid maze shortest path block.
// Depends on clk_i and rst_ni in the scope of each use.
`ifndef GRID_MAZE_SHORTEST_PATH_TOP_MACROS_SVH
`define GRID_MAZE_SHORTEST_PATH_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ant holds.
`define GMS_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ant holds.
`define GMS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gms_pkg.sv
// Shared types, constants and helpers of the grid maze shortest path block.
// No dependencies.
package gms_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int QW         = ROW_W + COL_W;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CELL_W     = 5;

  // Opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Cell kinds
  localparam logic [1:0] KIND_FLOOR = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_GOAL  = 2'd3;

  // Move directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] cell_kind;
  } gms_in_t;

  typedef struct packed {
    logic        goal_reached;
    logic [11:0] path_length;
    logic [1:0]  move_dir;
    logic        move_valid;
    logic        move_last;
  } gms_out_t;

  // Command from the front end to the core
  typedef struct packed {
    logic              load;
    logic              search;
    logic              read;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
  } gms_cmd_t;

  // Grid geometry in use
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [CNT_W-1:0] total;
  } gms_geom_t;

  // Clamp a written dimension into 1..maxv
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // Direction of the move that enters a neighbor, by search order
  function automatic logic [1:0] step_dir(input logic [1:0] d);
    logic [1:0] r;
    case (d)
      2'd0:    r = DIR_UP;
      2'd1:    r = DIR_LEFT;
      2'd2:    r = DIR_DOWN;
      default: r = DIR_RIGHT;
    endcase
    return r;
  endfunction

endpackage

// File: design/grid_maze_shortest_path_top.sv
// Top level of the grid maze shortest path block: geometry registers, load
// pointer and command decode. Depends on gms_pkg and gms_core.
//
// Loads and path reads may be issued back to back; a read result appears in
// the cycle after its command, after the move memory read. A solve keeps busy
// high for a scan of all rows*cols cells (ST_SCAN, ST_SCAN_LAST), the start
// read and write-back (ST_START_RD, ST_START_WR), then, for each cell taken
// from the frontier queue (ST_DEQ, ST_POP, ST_CHK), a check per direction,
// with one cell memory read and one write-back when the neighbor is on the
// grid; then the queue found empty or, once the goal is reached, a trace back
// that reads and stores each path move (ST_TR_RD, ST_TR_WB); then ST_DONE.
// The solve result strobes in the first cycle with busy low. Every result is
// a single-cycle strobe on result_valid_o; the receiver cannot stall, so
// results must be captured when they appear.
module grid_maze_shortest_path_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  gms_pkg::gms_in_t                   cmd_i,
  input  logic                               cfg_we_i,
  input  logic [gms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gms_pkg::DIM_W-1:0]          cfg_data_i,
  output logic                               result_valid_o,
  output gms_pkg::gms_out_t                  result_o
);
  import gms_pkg::*;

  logic [DIM_W-1:0]  rows_q, rows_d, cols_q, cols_d;
  logic [ADDR_W-1:0] lptr_q, lptr_d;
  logic              core_busy, accept;
  logic [CNT_W-1:0]  total;
  gms_cmd_t          cmd;
  gms_geom_t         geom;

  assign total  = CNT_W'(rows_q) * CNT_W'(cols_q);
  assign accept = start && !core_busy;
  assign busy   = core_busy;

  assign geom.rows  = rows_q;
  assign geom.cols  = cols_q;
  assign geom.total = total;

  // Decode the command transfer
  assign cmd.load   = accept && (cmd_i.opcode == OP_LOAD);
  assign cmd.search = accept && (cmd_i.opcode == OP_SOLVE);
  assign cmd.read   = accept && (cmd_i.opcode == OP_READ);
  assign cmd.kind   = cmd_i.cell_kind;
  assign cmd.addr   = lptr_q;

  // Update geometry and the load pointer
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    lptr_d = lptr_q;
    if (cmd.load) begin
      lptr_d = (CNT_W'(lptr_q) + CNT_W'(1) >= total) ? '0 : lptr_q + ADDR_W'(1);
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS: begin
          rows_d = clamp_dim(cfg_data_i, DIM_W'(MAX_ROWS));
          lptr_d = '0;
        end
        REG_COLS: begin
          cols_d = clamp_dim(cfg_data_i, DIM_W'(MAX_COLS));
          lptr_d = '0;
        end
        default: begin
          lptr_d = lptr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(MAX_ROWS);
      cols_q <= DIM_W'(MAX_COLS);
      lptr_q <= '0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      lptr_q <= lptr_d;
    end
  end

  gms_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .geom_i         (geom),
    .busy_o         (core_busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: design/gms_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/gms_core.sv
// Search core: cell, frontier and move memories, solve sequencer, read path.
// Depends on gms_pkg and gms_ram.
`include "grid_maze_shortest_path_top_macros.svh"
module gms_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gms_pkg::gms_cmd_t cmd_i,
  input  gms_pkg::gms_geom_t geom_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output gms_pkg::gms_out_t result_o
);
  import gms_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_START_RD, ST_START_WR, ST_DEQ, ST_POP,
    ST_CHK, ST_NB, ST_NB_CHK, ST_TR_RD, ST_TR_WB, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]  scan_r_q, scan_r_d;
  logic [COL_W-1:0]  scan_c_q, scan_c_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [QW-1:0]     pend_rc_q, pend_rc_d;
  logic [ADDR_W-1:0] start_q, start_d, goal_q, goal_d;
  logic [QW-1:0]     start_rc_q, start_rc_d;
  logic              goal_pres_q, goal_pres_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] count_q, count_d;
  logic [ADDR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [ROW_W-1:0]  cur_r_q, cur_r_d;
  logic [COL_W-1:0]  cur_c_q, cur_c_d;
  logic [ADDR_W-1:0] cur_idx_q, cur_idx_d;
  logic [1:0]        d_q, d_d;
  logic [ADDR_W-1:0] nb_idx_q, nb_idx_d;
  logic [QW-1:0]     nb_rc_q, nb_rc_d;
  logic              sol_done_q, sol_done_d;
  logic              rd_pend_q, rd_pend_d, rd_has_q, rd_has_d, rd_last_q, rd_last_d;

  logic              cell_we, cell_re;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic              q_we, q_re;
  logic [ADDR_W-1:0] q_waddr, q_raddr;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              mv_we, mv_re;
  logic [ADDR_W-1:0] mv_waddr, mv_raddr;
  logic [1:0]        mv_wdata, mv_rdata;

  logic [ADDR_W-1:0] cols_a;
  logic [DIM_W-1:0]  cur_r_p1, cur_c_p1, scan_c_p1;
  logic              nb_ok;
  logic [ADDR_W-1:0] nb_idx;
  logic [ROW_W-1:0]  nb_r;
  logic [COL_W-1:0]  nb_c;
  logic [1:0]        rd_kind;

  assign cols_a    = ADDR_W'(geom_i.cols);
  assign cur_r_p1  = DIM_W'(cur_r_q) + DIM_W'(1);
  assign cur_c_p1  = DIM_W'(cur_c_q) + DIM_W'(1);
  assign scan_c_p1 = DIM_W'(scan_c_q) + DIM_W'(1);
  assign rd_kind   = cell_rdata[1:0];

  // Neighbor for the current search step
  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_idx_q;
    nb_r   = cur_r_q;
    nb_c   = cur_c_q;
    case (d_q)
      2'd0: begin
        nb_ok  = (cur_r_q != '0);
        nb_idx = cur_idx_q - cols_a;
        nb_r   = cur_r_q - ROW_W'(1);
      end
      2'd1: begin
        nb_ok  = (cur_c_q != '0);
        nb_idx = cur_idx_q - ADDR_W'(1);
        nb_c   = cur_c_q - COL_W'(1);
      end
      2'd2: begin
        nb_ok  = (cur_r_p1 < geom_i.rows);
        nb_idx = cur_idx_q + cols_a;
        nb_r   = cur_r_q + ROW_W'(1);
      end
      default: begin
        nb_ok  = (cur_c_p1 < geom_i.cols);
        nb_idx = cur_idx_q + ADDR_W'(1);
        nb_c   = cur_c_q + COL_W'(1);
      end
    endcase
  end

  // Sequencer next state and memory controls
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_r_d    = scan_r_q;
    scan_c_d    = scan_c_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    pend_rc_d   = pend_rc_q;
    start_d     = start_q;
    start_rc_d  = start_rc_q;
    goal_d      = goal_q;
    goal_pres_d = goal_pres_q;
    found_d     = found_q;
    count_d     = count_q;
    rptr_d      = rptr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_r_d     = cur_r_q;
    cur_c_d     = cur_c_q;
    cur_idx_d   = cur_idx_q;
    d_d         = d_q;
    nb_idx_d    = nb_idx_q;
    nb_rc_d     = nb_rc_q;
    sol_done_d  = 1'b0;
    rd_pend_d   = 1'b0;
    rd_has_d    = 1'b0;
    rd_last_d   = 1'b1;

    cell_we    = 1'b0;
    cell_waddr = cmd_i.addr;
    cell_wdata = {1'b0, 2'b00, cmd_i.kind};
    cell_re    = 1'b0;
    cell_raddr = cnt_q[ADDR_W-1:0];
    q_we       = 1'b0;
    q_waddr    = tail_q[ADDR_W-1:0];
    q_wdata    = nb_rc_q;
    q_re       = 1'b0;
    q_raddr    = head_q[ADDR_W-1:0];
    mv_we      = 1'b0;
    mv_waddr   = count_q;
    mv_wdata   = cell_rdata[3:2];
    mv_re      = 1'b0;
    mv_raddr   = count_q - ADDR_W'(1) - rptr_q;

    // Finish a scan read: clear the seen mark, note start and goal
    if (pend_q) begin
      cell_we    = 1'b1;
      cell_waddr = pend_addr_q;
      cell_wdata = {1'b0, cell_rdata[3:0]};
      if (rd_kind == KIND_START) begin
        start_d    = pend_addr_q;
        start_rc_d = pend_rc_q;
      end
      if (rd_kind == KIND_GOAL) begin
        goal_d      = pend_addr_q;
        goal_pres_d = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.load) begin
          cell_we = 1'b1;
        end
        if (cmd_i.read) begin
          rd_pend_d = 1'b1;
          if (found_q && (rptr_q < count_q)) begin
            mv_re     = 1'b1;
            rd_has_d  = 1'b1;
            rd_last_d = (rptr_q + ADDR_W'(1) == count_q);
            rptr_d    = rptr_q + ADDR_W'(1);
          end
        end
        if (cmd_i.search) begin
          cnt_d       = '0;
          scan_r_d    = '0;
          scan_c_d    = '0;
          start_d     = '0;
          start_rc_d  = '0;
          goal_d      = '0;
          goal_pres_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cell_re     = 1'b1;
        pend_d      = 1'b1;
        pend_addr_d = cnt_q[ADDR_W-1:0];
        pend_rc_d   = {scan_r_q, scan_c_q};
        cnt_d       = cnt_q + CNT_W'(1);
        if (scan_c_p1 == geom_i.cols) begin
          scan_c_d = '0;
          scan_r_d = scan_r_q + ROW_W'(1);
        end else begin
          scan_c_d = scan_c_q + COL_W'(1);
        end
        if (cnt_q + CNT_W'(1) == geom_i.total) begin
          state_d = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        state_d = ST_START_RD;
      end
      ST_START_RD: begin
        cell_re    = 1'b1;
        cell_raddr = start_q;
        q_we       = 1'b1;
        q_waddr    = '0;
        q_wdata    = start_rc_q;
        head_d     = '0;
        tail_d     = CNT_W'(1);
        found_d    = 1'b0;
        count_d    = '0;
        rptr_d     = '0;
        state_d    = ST_START_WR;
      end
      ST_START_WR: begin
        cell_we    = 1'b1;
        cell_waddr = start_q;
        cell_wdata = {1'b1, cell_rdata[3:0]};
        state_d    = ST_DEQ;
      end
      ST_DEQ: begin
        if (head_q == tail_q) begin
          state_d = ST_DONE;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + CNT_W'(1);
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cur_r_d   = q_rdata[QW-1:COL_W];
        cur_c_d   = q_rdata[COL_W-1:0];
        cur_idx_d = ADDR_W'(q_rdata[QW-1:COL_W]) * cols_a
                  + ADDR_W'(q_rdata[COL_W-1:0]);
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        d_d = 2'd0;
        if (goal_pres_q && (cur_idx_q == goal_q)) begin
          found_d = 1'b1;
          state_d = ST_TR_RD;
        end else begin
          state_d = ST_NB;
        end
      end
      ST_NB: begin
        if (nb_ok) begin
          cell_re    = 1'b1;
          cell_raddr = nb_idx;
          nb_idx_d   = nb_idx;
          nb_rc_d    = {nb_r, nb_c};
          state_d    = ST_NB_CHK;
        end else if (d_q == 2'd3) begin
          state_d = ST_DEQ;
        end else begin
          d_d = d_q + 2'd1;
        end
      end
      ST_NB_CHK: begin
        // Enter floor or goal cells not yet seen
        if ((rd_kind == KIND_FLOOR || rd_kind == KIND_GOAL) && !cell_rdata[4]) begin
          cell_we    = 1'b1;
          cell_waddr = nb_idx_q;
          cell_wdata = {1'b1, step_dir(d_q), rd_kind};
          if (tail_q < CNT_W'(CELL_COUNT)) begin
            q_we   = 1'b1;
            tail_d = tail_q + CNT_W'(1);
          end
        end
        if (d_q == 2'd3) begin
          state_d = ST_DEQ;
        end else begin
          d_d     = d_q + 2'd1;
          state_d = ST_NB;
        end
      end
      ST_TR_RD: begin
        // Walk back from the goal; moves are stored goal first
        if (cur_idx_q == start_q || count_q == '1) begin
          state_d = ST_DONE;
        end else begin
          cell_re    = 1'b1;
          cell_raddr = cur_idx_q;
          state_d    = ST_TR_WB;
        end
      end
      ST_TR_WB: begin
        mv_we   = 1'b1;
        count_d = count_q + ADDR_W'(1);
        case (cell_rdata[3:2])
          DIR_UP:    cur_idx_d = cur_idx_q + cols_a;
          DIR_DOWN:  cur_idx_d = cur_idx_q - cols_a;
          DIR_LEFT:  cur_idx_d = cur_idx_q + ADDR_W'(1);
          default:   cur_idx_d = cur_idx_q - ADDR_W'(1);
        endcase
        state_d = ST_TR_RD;
      end
      ST_DONE: begin
        sol_done_d = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      scan_r_q    <= '0;
      scan_c_q    <= '0;
      pend_q      <= 1'b0;
      start_q     <= '0;
      start_rc_q  <= '0;
      goal_q      <= '0;
      goal_pres_q <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      rptr_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      d_q         <= '0;
      sol_done_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_has_q    <= 1'b0;
      rd_last_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_r_q    <= scan_r_d;
      scan_c_q    <= scan_c_d;
      pend_q      <= pend_d;
      start_q     <= start_d;
      start_rc_q  <= start_rc_d;
      goal_q      <= goal_d;
      goal_pres_q <= goal_pres_d;
      found_q     <= found_d;
      count_q     <= count_d;
      rptr_q      <= rptr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      d_q         <= d_d;
      sol_done_q  <= sol_done_d;
      rd_pend_q   <= rd_pend_d;
      rd_has_q    <= rd_has_d;
      rd_last_q   <= rd_last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_rc_q   <= pend_rc_d;
    cur_r_q     <= cur_r_d;
    cur_c_q     <= cur_c_d;
    cur_idx_q   <= cur_idx_d;
    nb_idx_q    <= nb_idx_d;
    nb_rc_q     <= nb_rc_d;
  end

  gms_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (cell_re),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  gms_ram #(.WIDTH(QW), .DEPTH(CELL_COUNT)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  gms_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_move_ram (
    .clk_i   (clk_i),
    .we_i    (mv_we),
    .waddr_i (mv_waddr),
    .wdata_i (mv_wdata),
    .re_i    (mv_re),
    .raddr_i (mv_raddr),
    .rdata_o (mv_rdata)
  );

  // Drive the result transfer
  assign busy_o                  = (state_q != ST_IDLE);
  assign result_valid_o          = sol_done_q | rd_pend_q;
  assign result_o.goal_reached   = found_q;
  assign result_o.path_length    = count_q;
  assign result_o.move_valid     = rd_pend_q & rd_has_q;
  assign result_o.move_dir       = (rd_pend_q && rd_has_q) ? mv_rdata : DIR_UP;
  assign result_o.move_last      = sol_done_q ? (count_q == '0) : rd_last_q;

  `GMS_ASSERT_SAME(a_queue_order, 1'b1, head_q <= tail_q, "queue head passed tail")
  `GMS_ASSERT_SAME(a_no_path_len, sol_done_q && !found_q, count_q == '0,
                   "path length without a path")
  `GMS_ASSERT_SAME(a_move_found, rd_pend_q && rd_has_q, found_q,
                   "path move read without a found path")
  `GMS_ASSERT_NEXT(a_solve_ends, state_q == ST_DONE, !busy_o && sol_done_q,
                   "solve result not issued")

endmodule

// File: tb/gms_checker.sv
`timescale 1ns / 100ps
// Result checker for the grid maze shortest path block: watches commands,
// register writes and results, predicts each result and compares. Depends on gms_pkg.
module gms_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  gms_pkg::gms_in_t              cmd_i,
  input  logic                          cfg_we_i,
  input  logic [gms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gms_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          result_valid_i,
  input  gms_pkg::gms_out_t             result_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            result_count_o
);
  import gms_pkg::*;

  // Shadow copy of the block: kind in bits 1:0, entry direction in bits 3:2
  logic [3:0]  grid_mem  [CELL_COUNT];
  logic [1:0]  trail_mem [CELL_COUNT];
  bit          visited   [CELL_COUNT];
  int unsigned wave_q    [CELL_COUNT];
  int unsigned grid_h, grid_w, load_ptr, start_idx, goal_idx;
  int unsigned trail_len, read_ptr;
  bit          goal_seen, goal_found;

  gms_out_t expected_results[$];

  assign pending_o = expected_results.size();

  function automatic int unsigned clamp_size(input logic [DIM_W-1:0] v, input int unsigned maxv);
    int unsigned r;
    r = v;
    if (r < 1) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  // Cell one move back from at, given the move that entered it
  function automatic int unsigned back_step(input int unsigned at, input logic [1:0] dir);
    int unsigned r;
    case (dir)
      DIR_UP:   r = at + grid_w;
      DIR_DOWN: r = at - grid_w;
      DIR_LEFT: r = at + 1;
      default:  r = at - 1;
    endcase
    return r;
  endfunction

  // Breadth-first search from the start, then trace the path back from the goal
  function automatic void run_search();
    int unsigned total, head, tail, cur, r, c, d, nb, k;
    logic [1:0] dir, nk;
    total = grid_h * grid_w;
    start_idx = 0;
    goal_idx = 0;
    goal_seen = 0;
    for (int i = 0; i < total; i++) begin
      if (grid_mem[i][1:0] == KIND_START) start_idx = i;
      if (grid_mem[i][1:0] == KIND_GOAL) begin
        goal_idx = i;
        goal_seen = 1;
      end
    end
    for (int i = 0; i < CELL_COUNT; i++) visited[i] = 0;
    goal_found = 0;
    trail_len = 0;
    read_ptr = 0;
    head = 0;
    tail = 0;
    wave_q[tail++] = start_idx;
    visited[start_idx] = 1;
    while (head < tail) begin
      cur = wave_q[head++];
      if (goal_seen && cur == goal_idx) begin
        goal_found = 1;
        break;
      end
      r = cur / grid_w;
      c = cur % grid_w;
      for (d = 0; d < 4; d++) begin
        if (d == 0) begin
          if (r == 0) continue;
          nb = cur - grid_w; dir = DIR_UP;
        end else if (d == 1) begin
          if (c == 0) continue;
          nb = cur - 1; dir = DIR_LEFT;
        end else if (d == 2) begin
          if (r + 1 >= grid_h) continue;
          nb = cur + grid_w; dir = DIR_DOWN;
        end else begin
          if (c + 1 >= grid_w) continue;
          nb = cur + 1; dir = DIR_RIGHT;
        end
        nk = grid_mem[nb][1:0];
        if ((nk != KIND_FLOOR && nk != KIND_GOAL) || visited[nb]) continue;
        visited[nb] = 1;
        grid_mem[nb] = {dir, nk};
        if (tail < CELL_COUNT) wave_q[tail++] = nb;
      end
    end
    if (!goal_found) return;
    cur = goal_idx;
    while (cur != start_idx && trail_len < total) begin
      cur = back_step(cur, grid_mem[cur][3:2]);
      if (cur >= total) break;
      trail_len++;
    end
    cur = goal_idx;
    for (k = 0; k < trail_len && cur < total; k++) begin
      trail_mem[trail_len - 1 - k] = grid_mem[cur][3:2];
      cur = back_step(cur, grid_mem[cur][3:2]);
    end
  endfunction

  // Work out the result of one accepted command, if it has one
  function automatic void predict_command(input gms_in_t cmd);
    int unsigned total;
    gms_out_t e;
    total = grid_h * grid_w;
    e = '0;
    case (cmd.opcode)
      OP_LOAD: begin
        if (load_ptr >= total) load_ptr = 0;
        grid_mem[load_ptr] = {2'b00, cmd.cell_kind};
        load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
        return;
      end
      OP_SOLVE: begin
        run_search();
        e.move_last = (trail_len == 0);
      end
      OP_READ: begin
        if (goal_found && read_ptr < trail_len && read_ptr < CELL_COUNT) begin
          e.move_dir = trail_mem[read_ptr];
          e.move_valid = 1'b1;
          e.move_last = (read_ptr + 1 == trail_len);
          read_ptr++;
        end else begin
          e.move_last = 1'b1;
        end
      end
      default: return;
    endcase
    e.goal_reached = goal_found;
    e.path_length = (trail_len > 4095) ? 12'd4095 : 12'(trail_len);
    expected_results.push_back(e);
  endfunction

  // Compare results first, then take register writes and new command transfers
  always @(posedge clk_i or negedge rst_ni) begin
    gms_out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < CELL_COUNT; i++) begin
        grid_mem[i] = '0;
        trail_mem[i] = '0;
      end
      grid_h = MAX_ROWS; grid_w = MAX_COLS;
      load_ptr = 0; start_idx = 0; goal_idx = 0; goal_seen = 0;
      trail_len = 0; read_ptr = 0; goal_found = 0;
      expected_results.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (result_valid_i) begin
        result_count_o++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no command waiting: %p", $time, result_i);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          if (result_i.goal_reached !== e.goal_reached || result_i.path_length !== e.path_length
              || result_i.move_dir !== e.move_dir || result_i.move_valid !== e.move_valid
              || result_i.move_last !== e.move_last) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, e, result_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROWS) grid_h = clamp_size(cfg_data_i, MAX_ROWS);
        else grid_w = clamp_size(cfg_data_i, MAX_COLS);
        load_ptr = 0;
      end
      if (start_i && !busy_i) predict_command(cmd_i);
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the grid maze shortest path block: drives mazes, solves and
// path reads, and reports the verdict. Depends on gms_pkg, gms_checker and the block.
module tb;
  import gms_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  gms_in_t           cmd_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DIM_W-1:0]  cfg_data_i = '0;
  logic              busy;
  logic              result_valid_o;
  gms_out_t          result_o;
  int                fail_count, pending, result_count;
  int                sent_items = 0, maze_count = 0, burst_left = 0, idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  grid_maze_shortest_path_top u_top (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .result_valid_o, .result_o
  );

  gms_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .result_valid_i(result_valid_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Abort when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Issue one command; hold start until the transfer, insert gaps between bursts
  task automatic send(input logic [1:0] op, input logic [1:0] kind);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    start = 1'b1;
    cmd_i = '{opcode: op, cell_kind: kind};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    sent_items++;
  endtask

  // Drop start and wait until every result is in and the block is quiet
  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Solve, then read moves with some noise mixed in
  task automatic solve_and_read(input int reads);
    send(OP_SOLVE, 2'($urandom));
    for (int i = 0; i < reads; i++) begin
      case ($urandom_range(0, 19))
        0: send(OP_NOP, 2'($urandom));
        1: send(OP_LOAD, KIND_FLOOR);
        default: send(OP_READ, 2'($urandom));
      endcase
    end
  endtask

  // Random maze: a start, a goal and scattered walls, each cell replaced by a noisy kind with a chance of one in four
  task automatic random_maze(input int h, input int w);
    int total, s, g, wall_pct, r;
    logic [1:0] k;
    total = h * w;
    s = $urandom_range(0, total - 1);
    g = $urandom_range(0, total - 1);
    wall_pct = $urandom_range(0, 45);
    settle();
    write_reg(REG_ROWS, DIM_W'(h));
    write_reg(REG_COLS, DIM_W'(w));
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        k = (r < 55) ? KIND_FLOOR : (r < 80) ? KIND_WALL : (r < 90) ? KIND_START : KIND_GOAL;
      end else if (i == g) begin
        k = KIND_GOAL;
      end else if (i == s) begin
        k = KIND_START;
      end else begin
        k = ($urandom_range(0, 99) < wall_pct) ? KIND_WALL : KIND_FLOOR;
      end
      send(OP_LOAD, k);
    end
    maze_count++;
    solve_and_read($urandom_range(0, 2 * (h + w) + 2));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reads and a no-op command before any solve
    send(OP_READ, KIND_GOAL);
    send(OP_NOP, KIND_START);
    send(OP_READ, KIND_FLOOR);
    settle();

    // Zero sizes act as 1x1: goal on the start cell, then no goal at all
    write_reg(REG_ROWS, '0);
    write_reg(REG_COLS, '0);
    send(OP_LOAD, KIND_GOAL);
    solve_and_read(1);
    send(OP_LOAD, KIND_WALL);
    solve_and_read(1);
    settle();

    // 2x2, start bottom right, goal top left: moves up then left
    write_reg(REG_ROWS, 7'd2);
    write_reg(REG_COLS, 7'd2);
    send(OP_LOAD, KIND_GOAL);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_START);
    solve_and_read(3);
    // No start: search from a wall at the corner, moves down then right
    send(OP_LOAD, KIND_WALL);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_GOAL);
    solve_and_read(3);
    settle();

    // 3x3 loaded with two starts, two goals and one cell past the end, which wraps and puts a wall on the first start
    write_reg(REG_ROWS, 7'd3);
    write_reg(REG_COLS, 7'd3);
    send(OP_LOAD, KIND_START);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_WALL);
    send(OP_LOAD, KIND_START);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_GOAL);
    send(OP_LOAD, KIND_FLOOR);
    send(OP_LOAD, KIND_GOAL);
    send(OP_LOAD, KIND_WALL);
    solve_and_read(3);

    // Random mazes, mostly small
    while (sent_items < 400) begin
      if ($urandom_range(0, 9) == 0) random_maze($urandom_range(1, 16), $urandom_range(1, 16));
      else random_maze($urandom_range(1, 7), $urandom_range(1, 7));
    end

    // One row at full width, columns written above the limit, reads past the end
    settle();
    write_reg(REG_ROWS, 7'd1);
    write_reg(REG_COLS, 7'd127);
    for (int i = 0; i < MAX_COLS; i++) begin
      send(OP_LOAD, (i == 0) ? KIND_START : (i == MAX_COLS - 1) ? KIND_GOAL : KIND_FLOOR);
    end
    maze_count++;
    solve_and_read(MAX_COLS + 2);
    settle();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d commands over %0d random mazes and the directed grids;", sent_items,
             maze_count);
    $display("checked %0d results, %0d mismatches.", result_count, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/gms_pkg.sv
design/gms_ram.sv
design/gms_core.sv
design/grid_maze_shortest_path_top.sv
tb/gms_checker.sv
tb/tb.sv
